@@ rtl/xthdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xthdc_pkg
// Types, codes and geometry constants of the XT disk controller.
// ----------------------------------------------------------------------------
package xthdc_pkg;

  localparam int Cylinders   = 4;
  localparam int Heads       = 2;
  localparam int Sectors     = 17;
  localparam int SectorBytes = 512;
  localparam int StoreBytes  = Cylinders * Heads * Sectors * SectorBytes;
  localparam int AddrW       = $clog2(StoreBytes);

  typedef logic [AddrW-1:0] addr_t;

  typedef enum logic [3:0] {
    FN_DATA_WR   = 4'd0,
    FN_DATA_RD   = 4'd1,
    FN_RESET_WR  = 4'd2,
    FN_STATUS_RD = 4'd3,
    FN_SELECT_WR = 4'd4,
    FN_CONFIG_RD = 4'd5,
    FN_MASK_WR   = 4'd6,
    FN_DMA_OUT   = 4'd7,
    FN_DMA_IN    = 4'd8
  } func_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CMD    = 4'd1,
    PH_P1     = 4'd2,
    PH_P2     = 4'd3,
    PH_P3     = 4'd4,
    PH_P4     = 4'd5,
    PH_P5     = 4'd6,
    PH_INIT   = 4'd7,
    PH_PIO_RD = 4'd8,
    PH_STATUS = 4'd9
  } phase_t;

  // controller sequencing: store clearing pass after reset, wait for a word, execute
  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} ctl_t;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_BAD_WR   = 3'd1;
  localparam logic [2:0] ERR_BAD_RD   = 3'd2;
  localparam logic [2:0] ERR_UNK_CMD  = 3'd3;
  localparam logic [2:0] ERR_PIO_WR   = 3'd4;
  localparam logic [2:0] ERR_OVERRUN  = 3'd5;
  localparam logic [2:0] ERR_OUTSIDE  = 3'd6;

  localparam logic [1:0] DMA_NONE = 2'd0;
  localparam logic [1:0] DMA_READ = 2'd1;
  localparam logic [1:0] DMA_WRITE = 2'd2;

  localparam logic [7:0] CMD_TEST   = 8'h00;
  localparam logic [7:0] CMD_SENSE  = 8'h03;
  localparam logic [7:0] CMD_RECAL  = 8'h01;
  localparam logic [7:0] CMD_VERIFY = 8'h05;
  localparam logic [7:0] CMD_READ   = 8'h08;
  localparam logic [7:0] CMD_WRITE  = 8'h0A;
  localparam logic [7:0] CMD_INIT   = 8'h0C;
  localparam logic [7:0] CMD_DIAG   = 8'hE4;

  localparam logic [5:0] ST_REQ  = 6'h01;
  localparam logic [5:0] ST_IO   = 6'h02;
  localparam logic [5:0] ST_CD   = 6'h04;
  localparam logic [5:0] ST_XBSY = 6'h08;
  localparam logic [5:0] ST_IRQ  = 6'h20;

  typedef struct packed {
    logic [3:0] func;
    logic [7:0] wdata;
  } req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq_raised;
    logic [1:0] dma_start;
    logic [2:0] error_code;
  } rsp_t;

endpackage

@@ rtl/xthdc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xthdc_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface xthdc_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/xthdc_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xthdc_store
// Sector store: one port, registered read, write or read each cycle.
// ----------------------------------------------------------------------------
module xthdc_store (
  input  logic                 clk,
  input  logic                 we,
  input  xthdc_pkg::addr_t     addr,
  input  logic [7:0]           wd,
  output logic [7:0]           rd
);
  import xthdc_pkg::*;

  logic [7:0] mem [StoreBytes];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wd;
    end
    rd <= mem[addr];
  end
endmodule

@@ rtl/xt_hard_disk_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xt_hard_disk_controller
// XT-style disk controller register model with an attached sector store.
// ----------------------------------------------------------------------------
// channel  dir  word
// req      in   func, wdata
// rsp      out  rdata, irq_raised, dma_start, error_code
// cfg      in   cfg_we, cfg_wdata (drive_config)
//
// An accepted access forms the address and reads the store in the accepting
// cycle, then updates state and the result in S_EXEC; the single store port's
// registered read sets that order. After reset a clearing pass writes zero
// to all 69632 store bytes, one a cycle; no word is accepted until it ends.
// A result held by a stalled sink blocks the next word only until taken.
// ----------------------------------------------------------------------------
module xt_hard_disk_controller (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [7:0] cfg_wdata,
  xthdc_if.sink   req,
  xthdc_if.source rsp
);
  import xthdc_pkg::*;

  ctl_t        ctl, ctl_next;
  addr_t       clr_addr;
  logic [7:0]  drive_config;
  phase_t      phase;
  logic [7:0]  cmd [6];
  logic [5:0]  status_bits;
  logic [1:0]  mask_bits;
  logic [7:0]  completion;
  logic [9:0]  byte_cnt;
  logic        drive_sel;
  logic [4:0]  head_num;
  logic [5:0]  sector_num;
  logic [9:0]  cyl_num;
  logic [3:0]  func;
  logic [7:0]  wdata;
  logic        out_valid;
  rsp_t        out_word;

  logic [7:0]  st_rd;
  logic        st_we;
  addr_t       st_addr;
  logic [26:0] lin;
  logic        in_range;

  always_comb begin
    lin = 27'((({17'd0, cyl_num} * 27'(Heads) + 27'(head_num)) * 27'(Sectors)
          + 27'(sector_num)) * 27'(SectorBytes) + 27'(byte_cnt));
  end
  assign in_range = lin < 27'(StoreBytes);

  wire accept = req.valid && req.ready;
  assign req.ready = (ctl == S_IDLE) && (!out_valid || rsp.ready);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

  always_comb begin
    st_we   = 1'b0;
    st_addr = lin[AddrW-1:0];
    if (ctl == S_CLEAR) begin
      st_we   = 1'b1;
      st_addr = clr_addr;
    end else if (accept && req.data.func == FN_DMA_IN && in_range) begin
      st_we = 1'b1;
    end
  end

  xthdc_store u_store (
    .clk (clk), .we (st_we), .addr (st_addr), .wd (st_we && ctl != S_CLEAR ?
      req.data.wdata : 8'd0), .rd (st_rd)
  );

  always_comb begin
    ctl_next = ctl;
    case (ctl)
      S_CLEAR: if (clr_addr == addr_t'(StoreBytes - 1)) ctl_next = S_IDLE;
      S_IDLE:  if (accept) ctl_next = S_EXEC;
      S_EXEC:  ctl_next = S_IDLE;
      default: ctl_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      ctl <= ctl_next;
      if (ctl == S_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
    if (accept) begin
      func  <= req.data.func;
      wdata <= req.data.wdata;
    end
  end

  // execute one word
  always_ff @(posedge clk) begin : exec
    logic [7:0] rd;
    logic irq;
    logic [1:0] dma;
    logic [2:0] err;
    logic [5:0] sb;
    logic [9:0] bc;
    logic fin;
    logic [7:0] fcode;
    if (rst) begin
      drive_config <= 8'hFF;
      phase <= PH_IDLE;
      for (int i = 0; i < 6; i++) cmd[i] <= '0;
      status_bits <= '0;
      mask_bits <= '0;
      completion <= '0;
      byte_cnt <= '0;
      drive_sel <= '0;
      head_num <= '0;
      sector_num <= '0;
      cyl_num <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) drive_config <= cfg_wdata;
      if (ctl == S_EXEC) begin
        rd = '0; irq = 1'b0; dma = DMA_NONE; err = ERR_OK;
        sb = status_bits; fin = 1'b0; fcode = '0;
        case (func)
          FN_DATA_WR: begin
            if (phase >= PH_CMD && phase <= PH_P4) begin
              cmd[3'(phase - PH_CMD)] <= wdata;
              phase <= phase_t'(phase + 4'd1);
            end else if (phase == PH_P5) begin
              cmd[5] <= wdata;
              case (cmd[0])
                CMD_READ, CMD_WRITE: begin
                  drive_sel <= cmd[1][5];
                  head_num <= cmd[1][4:0];
                  sector_num <= cmd[2][5:0];
                  cyl_num <= {cmd[2][7:6], cmd[3]};
                  byte_cnt <= '0;
                  if (mask_bits[0]) begin
                    dma = cmd[0] == CMD_READ ? DMA_READ : DMA_WRITE;
                    irq = mask_bits[1];
                    phase <= PH_STATUS;
                  end else if (cmd[0] == CMD_READ) begin
                    sb = sb & ~ST_CD;
                    phase <= PH_PIO_RD;
                  end else begin
                    err = ERR_PIO_WR;
                    phase <= PH_STATUS;
                  end
                  sb = sb | ST_IO;
                end
                CMD_VERIFY, CMD_SENSE: begin fin = 1'b1; fcode = 8'h20; end
                CMD_INIT: begin byte_cnt <= '0; phase <= PH_INIT; end
                CMD_RECAL: begin fin = 1'b1; fcode = cmd[1][5] ? 8'h22 : 8'h00; end
                CMD_TEST, CMD_DIAG: fin = 1'b1;
                default: begin fin = 1'b1; err = ERR_UNK_CMD; end
              endcase
            end else if (phase == PH_INIT) begin
              bc = byte_cnt + 10'd1;
              byte_cnt <= bc;
              if (bc >= 10'd8) fin = 1'b1;
            end else begin
              err = ERR_BAD_WR;
            end
          end
          FN_DATA_RD: begin
            if (phase == PH_STATUS) begin
              sb = sb & ~(ST_REQ | ST_XBSY | ST_CD | ST_IO);
              phase <= PH_IDLE;
              rd = completion;
            end else if (phase == PH_PIO_RD) begin
              if (!in_range) err = ERR_OUTSIDE;
              else begin
                rd = st_rd;
                bc = byte_cnt + 10'd1;
                byte_cnt <= bc;
                if ({1'b0, bc} >= 11'(SectorBytes)) begin
                  completion <= '0;
                  irq = mask_bits[1];
                  phase <= PH_STATUS;
                end
              end
            end else begin
              err = ERR_BAD_RD;
            end
          end
          FN_RESET_WR: phase <= PH_IDLE;
          FN_STATUS_RD: begin rd = {2'b00, status_bits}; sb = sb & ~ST_IRQ; end
          FN_SELECT_WR: begin
            sb = (sb | ST_REQ | ST_XBSY | ST_CD) & ~ST_IO;
            phase <= PH_CMD;
          end
          FN_CONFIG_RD: rd = drive_config;
          FN_MASK_WR: mask_bits <= wdata[1:0];
          FN_DMA_OUT, FN_DMA_IN: begin
            if (!in_range) err = ERR_OUTSIDE;
            else begin
              if (func == FN_DMA_OUT) rd = st_rd;
              if ({1'b0, byte_cnt} + 11'd1 < 11'(SectorBytes)) byte_cnt <= byte_cnt + 10'd1;
              else begin
                byte_cnt <= '0;
                if ({1'b0, sector_num} + 7'd1 < 7'(Sectors)) sector_num <= sector_num + 6'd1;
                else begin
                  sector_num <= '0;
                  if ({1'b0, head_num} + 6'd1 < 6'(Heads)) head_num <= head_num + 5'd1;
                  else begin
                    head_num <= '0;
                    if ({1'b0, cyl_num} + 11'd1 < 11'(Cylinders)) cyl_num <= cyl_num + 10'd1;
                    else begin
                      cyl_num <= '0;
                      err = ERR_OVERRUN;
                    end
                  end
                end
              end
            end
          end
          default: ;
        endcase
        if (fin) begin
          completion <= fcode;
          irq = mask_bits[1];
          sb = sb | ST_IO;
          phase <= PH_STATUS;
        end
        if (irq) sb = sb | ST_IRQ;
        status_bits <= sb;
        out_word <= '{rdata: rd, irq_raised: irq, dma_start: dma, error_code: err};
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
